[rtl/fcbs_pkg.sv]
// Package for the frustum culling block: shared widths, input mode codes,
// the command kinds and the command record that the front passes to the back.
// No dependencies.
package fcbs_pkg;

   localparam int WORD_W      = 32;
   localparam int OP_W        = WORD_W + 1;
   localparam int PROD_W      = 2 * OP_W;
   localparam int ACC_W       = PROD_W + 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_BOX    = 2'd1;
   localparam logic [1:0] MODE_SPHERE = 2'd2;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_BOX    = 2'd1,
      KIND_SPHERE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [2:0]                 plane_index;
      logic signed [WORD_W-1:0]   ax;
      logic signed [WORD_W-1:0]   ay;
      logic signed [WORD_W-1:0]   az;
      logic signed [WORD_W-1:0]   aw;
      logic signed [WORD_W-1:0]   bx;
      logic signed [WORD_W-1:0]   by;
      logic signed [WORD_W-1:0]   bz;
   } cmd_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] a;
      logic signed [WORD_W-1:0] b;
      logic signed [WORD_W-1:0] c;
      logic signed [WORD_W-1:0] d;
   } plane_type;

endpackage

[rtl/fcbs_front.sv]
// Front part of the culling block: decodes incoming transfers, drops those
// that do nothing, and queues the rest for the back part.
// Depends on fcbs_pkg.
module fcbs_front import fcbs_pkg::*; #(
   parameter int NUM_PLANES = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [2:0]               req_plane_index,
   input  logic signed [WORD_W-1:0] req_ax,
   input  logic signed [WORD_W-1:0] req_ay,
   input  logic signed [WORD_W-1:0] req_az,
   input  logic signed [WORD_W-1:0] req_aw,
   input  logic signed [WORD_W-1:0] req_bx,
   input  logic signed [WORD_W-1:0] req_by,
   input  logic signed [WORD_W-1:0] req_bz,
   output logic                     q_valid,
   output cmd_type                  q_cmd,
   input  logic                     q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            cmd;
   logic               keep;
   logic               push;

   // Decode: loads to a slot that does not exist and the unused mode are dropped.
   always_comb begin
      cmd.plane_index = req_plane_index;
      cmd.ax = req_ax;
      cmd.ay = req_ay;
      cmd.az = req_az;
      cmd.aw = req_aw;
      cmd.bx = req_bx;
      cmd.by = req_by;
      cmd.bz = req_bz;
      cmd.kind = KIND_LOAD;
      keep = 1'b0;
      case (req_mode)
         MODE_LOAD: begin
            cmd.kind = KIND_LOAD;
            keep = (int'(req_plane_index) < NUM_PLANES);
         end
         MODE_BOX: begin
            cmd.kind = KIND_BOX;
            keep = 1'b1;
         end
         MODE_SPHERE: begin
            cmd.kind = KIND_SPHERE;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

[rtl/fcbs_back.sv]
// Back part of the culling block: holds the plane store, writes loads in
// order and runs tests through one shared multiply-accumulate pipeline.
// Depends on fcbs_pkg.
module fcbs_back import fcbs_pkg::*; #(
   parameter int NUM_PLANES = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_visible
);

   localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam logic signed [OP_W-1:0] SCALE = OP_W'(1) << FRAC_BITS;

   localparam logic [1:0] TERM_X     = 2'd0;
   localparam logic [1:0] TERM_Y     = 2'd1;
   localparam logic [1:0] TERM_Z     = 2'd2;
   localparam logic [1:0] TERM_CONST = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ISSUE  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   plane_type                  plane_ff [NUM_PLANES];
   cmd_type                    item_ff;
   logic [PLANE_W-1:0]         plane_cnt_ff, plane_cnt_in;
   logic [1:0]                 term_ff, term_in;

   logic signed [OP_W-1:0]     coef_ff, coef_in;
   logic signed [OP_W-1:0]     op_ff, op_in;
   logic                       a_vld_ff, a_vld_in;
   logic                       a_first_ff, a_last_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       b_vld_ff, b_first_ff, b_last_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_sum;
   logic                       vis_ff, vis_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_visible_ff;

   plane_type                  cur;
   logic signed [WORD_W-1:0]   lo_v, hi_v, coef_w, box_op, sph_op;
   logic                       start_test, do_load, finish;
   logic                       slot_free;

   assign cur       = plane_ff[plane_cnt_ff];
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign q_pop      = q_valid && (state_ff == ST_IDLE);
   assign do_load    = q_pop && (q_cmd.kind == KIND_LOAD);
   assign start_test = q_pop && (q_cmd.kind != KIND_LOAD);
   assign finish     = (state_ff == ST_FINISH) && !a_vld_ff && !b_vld_ff && slot_free;

   // Operand selection. For a box the corner that maximizes the plane
   // function takes the larger bound where the coefficient is non-negative.
   always_comb begin
      coef_w = cur.a;
      lo_v   = item_ff.ax;
      hi_v   = item_ff.bx;
      sph_op = item_ff.ax;
      case (term_ff)
         TERM_X: begin
            coef_w = cur.a;
            lo_v   = (item_ff.ax < item_ff.bx) ? item_ff.ax : item_ff.bx;
            hi_v   = (item_ff.ax < item_ff.bx) ? item_ff.bx : item_ff.ax;
            sph_op = item_ff.ax;
         end
         TERM_Y: begin
            coef_w = cur.b;
            lo_v   = (item_ff.ay < item_ff.by) ? item_ff.ay : item_ff.by;
            hi_v   = (item_ff.ay < item_ff.by) ? item_ff.by : item_ff.ay;
            sph_op = item_ff.ay;
         end
         TERM_Z: begin
            coef_w = cur.c;
            lo_v   = (item_ff.az < item_ff.bz) ? item_ff.az : item_ff.bz;
            hi_v   = (item_ff.az < item_ff.bz) ? item_ff.bz : item_ff.az;
            sph_op = item_ff.az;
         end
         default: begin
            coef_w = cur.d;
         end
      endcase
      box_op = coef_w[WORD_W-1] ? lo_v : hi_v;
      if (term_ff == TERM_CONST) begin
         coef_in = SCALE;
         op_in   = OP_W'(cur.d) +
                   ((item_ff.kind == KIND_SPHERE) ? OP_W'(item_ff.aw) : OP_W'(0));
      end else begin
         coef_in = OP_W'(coef_w);
         op_in   = (item_ff.kind == KIND_BOX) ? OP_W'(box_op) : OP_W'(sph_op);
      end
   end

   // Sequencer over planes and terms.
   always_comb begin
      state_in     = state_ff;
      plane_cnt_in = plane_cnt_ff;
      term_in      = term_ff;
      a_vld_in     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start_test) begin
               state_in     = ST_ISSUE;
               plane_cnt_in = '0;
               term_in      = TERM_X;
            end
         end
         ST_ISSUE: begin
            a_vld_in = 1'b1;
            term_in  = term_ff + 2'd1;
            if (term_ff == TERM_CONST) begin
               if (int'(plane_cnt_ff) == NUM_PLANES - 1) begin
                  state_in = ST_FINISH;
               end else begin
                  plane_cnt_in = plane_cnt_ff + PLANE_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign acc_sum = (b_first_ff ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);

   always_comb begin
      vis_in = vis_ff;
      if (start_test) begin
         vis_in = 1'b1;
      end else if (b_vld_ff && b_last_ff && !(acc_sum > ACC_W'(0))) begin
         vis_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plane_cnt_ff <= '0;
         term_ff      <= TERM_X;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         vis_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         plane_cnt_ff <= plane_cnt_in;
         term_ff      <= term_in;
         a_vld_ff     <= a_vld_in;
         b_vld_ff     <= a_vld_ff;
         vis_ff       <= vis_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_load) begin
            plane_ff[q_cmd.plane_index[PLANE_W-1:0]] <= '{
               a: q_cmd.ax, b: q_cmd.ay, c: q_cmd.az, d: q_cmd.aw};
         end
      end
   end

   // Payload registers of the datapath.
   always_ff @(posedge clock) begin
      if (start_test) begin
         item_ff <= q_cmd;
      end
      coef_ff    <= coef_in;
      op_ff      <= op_in;
      a_first_ff <= (term_ff == TERM_X);
      a_last_ff  <= (term_ff == TERM_CONST);
      prod_ff    <= coef_ff * op_ff;
      b_first_ff <= a_first_ff;
      b_last_ff  <= a_last_ff;
      if (b_vld_ff) begin
         acc_ff <= acc_sum;
      end
      if (finish) begin
         rsp_visible_ff <= vis_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

[rtl/frustum_cull_box_sphere_top.sv]
// Top level of the frustum culling block for axis-aligned boxes and spheres.
// Depends on fcbs_pkg, fcbs_front and fcbs_back.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/req_stall | mode, plane_index, ax..aw, bx..bz
//   rsp     | out       | rsp_valid/rsp_stall | visible
//
// A plane load is written into the plane store at the clock edge where it
// leaves the queue and makes no result transfer. A box or sphere test runs
// in the back part as follows: the command is taken from the queue, one
// shared 33x33 multiplier handles one term per cycle (three dot-product terms
// and the offset term for each plane), the operand and product registers
// drain and, once the result slot is free, the result register is written.
// Reset is synchronous and clears the plane store to all-zero planes, the
// queue, the sequencer and the result valid flag.
// A two-entry queue keeps taking transfers while a test is running or a
// result is held by rsp_stall; req_stall rises only when that queue is full.
module frustum_cull_box_sphere_top import fcbs_pkg::*; #(
   parameter int NUM_PLANES = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [2:0]               req_plane_index,
   input  logic signed [WORD_W-1:0] req_ax,
   input  logic signed [WORD_W-1:0] req_ay,
   input  logic signed [WORD_W-1:0] req_az,
   input  logic signed [WORD_W-1:0] req_aw,
   input  logic signed [WORD_W-1:0] req_bx,
   input  logic signed [WORD_W-1:0] req_by,
   input  logic signed [WORD_W-1:0] req_bz,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_visible
);

   // Commands pass from front to back in arrival order, so a load never
   // overtakes a test that was accepted before it.
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   fcbs_front #(
      .NUM_PLANES (NUM_PLANES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_plane_index (req_plane_index),
      .req_ax          (req_ax),
      .req_ay          (req_ay),
      .req_az          (req_az),
      .req_aw          (req_aw),
      .req_bx          (req_bx),
      .req_by          (req_by),
      .req_bz          (req_bz),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop)
   );

   // The back part accumulates each plane's sum exactly and clears the
   // visible flag when a sum is not strictly positive.
   fcbs_back #(
      .NUM_PLANES (NUM_PLANES),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_visible (rsp_visible)
   );

endmodule

[verif/cull_checker.sv]
`timescale 1ns / 1ps
// Checker for the frustum culling block: keeps its own copy of the plane store,
// predicts the visible bit of every accepted test and compares each result.
// Depends on fcbs_pkg.
module cull_checker import fcbs_pkg::*; #(
   parameter int NUM_PLANES = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [2:0]               req_plane_index,
   input  logic signed [WORD_W-1:0] req_ax,
   input  logic signed [WORD_W-1:0] req_ay,
   input  logic signed [WORD_W-1:0] req_az,
   input  logic signed [WORD_W-1:0] req_aw,
   input  logic signed [WORD_W-1:0] req_bx,
   input  logic signed [WORD_W-1:0] req_by,
   input  logic signed [WORD_W-1:0] req_bz,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_visible,
   output int                       mismatch_count,
   output int                       visible_outstanding,
   output int                       results_checked,
   output int                       visible_seen
);

   typedef logic signed [95:0] wide_sum_type;

   plane_type plane_copy [NUM_PLANES];
   bit        visible_expected [$];

   function automatic wide_sum_type widen(input logic signed [WORD_W-1:0] v);
      return v;
   endfunction

   // Largest of the two products along one axis, i.e. the corner that pushes
   // the plane function highest.
   function automatic wide_sum_type best_term(input logic signed [WORD_W-1:0] coef,
                                              input logic signed [WORD_W-1:0] lo,
                                              input logic signed [WORD_W-1:0] hi);
      wide_sum_type t_lo;
      wide_sum_type t_hi;
      t_lo = widen(coef) * widen(lo);
      t_hi = widen(coef) * widen(hi);
      return (t_lo > t_hi) ? t_lo : t_hi;
   endfunction

   function automatic bit box_visible(input logic signed [WORD_W-1:0] x0, y0, z0,
                                      input logic signed [WORD_W-1:0] x1, y1, z1);
      wide_sum_type total;
      for (int i = 0; i < NUM_PLANES; i++) begin
         total = (widen(plane_copy[i].d) <<< FRAC_BITS)
               + best_term(plane_copy[i].a, x0, x1)
               + best_term(plane_copy[i].b, y0, y1)
               + best_term(plane_copy[i].c, z0, z1);
         if (total <= 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit sphere_visible(input logic signed [WORD_W-1:0] cx, cy, cz,
                                         input logic signed [WORD_W-1:0] radius);
      wide_sum_type total;
      for (int i = 0; i < NUM_PLANES; i++) begin
         total = widen(plane_copy[i].a) * widen(cx)
               + widen(plane_copy[i].b) * widen(cy)
               + widen(plane_copy[i].c) * widen(cz)
               + (widen(plane_copy[i].d) <<< FRAC_BITS)
               + (widen(radius) <<< FRAC_BITS);
         if (total <= 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input bit want, input bit got);
      $display("MISMATCH at %0t: %s (expected visible=%0d, got %0d)",
               $time, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      bit want;
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) plane_copy[i] = '0;
         visible_expected.delete();
         mismatch_count  = 0;
         results_checked = 0;
         visible_seen    = 0;
      end else begin
         if (req_valid && !req_stall) begin
            case (req_mode)
               MODE_LOAD: begin
                  if (req_plane_index < NUM_PLANES)
                     plane_copy[req_plane_index] = '{req_ax, req_ay, req_az, req_aw};
               end
               MODE_BOX: begin
                  visible_expected.push_back(
                     box_visible(req_ax, req_ay, req_az, req_bx, req_by, req_bz));
               end
               MODE_SPHERE: begin
                  visible_expected.push_back(
                     sphere_visible(req_ax, req_ay, req_az, req_aw));
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (visible_expected.size() == 0) begin
               report_mismatch("result with no test waiting", 1'b0, rsp_visible);
            end else begin
               want = visible_expected.pop_front();
               results_checked++;
               if (rsp_visible === 1'b1) visible_seen++;
               if (rsp_visible !== want)
                  report_mismatch("visible bit wrong", want, rsp_visible);
            end
         end
      end
      visible_outstanding <= visible_expected.size();
   end

endmodule

[verif/tb_frustum_cull_box_sphere_top.sv]
`timescale 1ns / 1ps
// Testbench top for the frustum culling block: makes the request stimulus and
// the result-side stalls and gives the verdict. Depends on fcbs_pkg, the block
// frustum_cull_box_sphere_top and the cull_checker module.
module tb_frustum_cull_box_sphere_top;
   import fcbs_pkg::*;

   localparam int NUM_PLANES   = 6;
   localparam int FRAC_BITS    = 16;
   localparam int ONE          = 1 << FRAC_BITS;
   localparam int TARGET_ITEMS = 1850;
   // Long enough for a test to pass through the back part, with some margin.
   localparam int DRAIN_CYCLES = 4 * NUM_PLANES + 4 + 16;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 600000;

   // The fourth mode code has no meaning; the block must drop such transfers.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]               mode;
      logic [2:0]               slot;
      logic signed [WORD_W-1:0] ax, ay, az, aw, bx, by, bz;
   } cull_item_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_mode = '0;
   logic [2:0]               req_plane_index = '0;
   logic signed [WORD_W-1:0] req_ax = '0;
   logic signed [WORD_W-1:0] req_ay = '0;
   logic signed [WORD_W-1:0] req_az = '0;
   logic signed [WORD_W-1:0] req_aw = '0;
   logic signed [WORD_W-1:0] req_bx = '0;
   logic signed [WORD_W-1:0] req_by = '0;
   logic signed [WORD_W-1:0] req_bz = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_visible;

   int mismatch_count;
   int visible_outstanding;
   int results_checked;
   int visible_seen;

   // Knobs shared between the stimulus process and the receiver process, and the watchdog's cycle counter.
   int rx_stall_pct  = 0;
   int hold_asks     = 0;
   int holds_served  = 0;
   int cycle_count   = 0;

   // Tallies of accepted transfers, for the summary.
   int loads_sent    = 0;
   int boxes_sent    = 0;
   int spheres_sent  = 0;
   int ignored_sent  = 0;
   int useful_issued = 0;

   frustum_cull_box_sphere_top #(
      .NUM_PLANES (NUM_PLANES),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_plane_index (req_plane_index),
      .req_ax          (req_ax),
      .req_ay          (req_ay),
      .req_az          (req_az),
      .req_aw          (req_aw),
      .req_bx          (req_bx),
      .req_by          (req_by),
      .req_bz          (req_bz),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_visible     (rsp_visible)
   );

   cull_checker #(
      .NUM_PLANES (NUM_PLANES),
      .FRAC_BITS  (FRAC_BITS)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_plane_index     (req_plane_index),
      .req_ax              (req_ax),
      .req_ay              (req_ay),
      .req_az              (req_az),
      .req_aw              (req_aw),
      .req_bx              (req_bx),
      .req_by              (req_by),
      .req_bz              (req_bz),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_visible         (rsp_visible),
      .mismatch_count      (mismatch_count),
      .visible_outstanding (visible_outstanding),
      .results_checked     (results_checked),
      .visible_seen        (visible_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. The slowest correct run is far below this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, visible_outstanding);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver side. It stalls in random bursts at a rate the stimulus sets per
   // phase, and on request holds rsp_stall for a long stretch so that the
   // result register and the input queue fill up and req_stall rises.
   initial begin : receiver
      forever begin
         if (holds_served != hold_asks) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Item builders. Fields a transfer does not use carry random bits so that
   // every input bit toggles over the run.
   // ---------------------------------------------------------------------

   function automatic cull_item_type make_item(input logic [1:0] mode,
                                               input logic [2:0] slot,
                                               input logic signed [WORD_W-1:0] ax, ay, az, aw,
                                               input logic signed [WORD_W-1:0] bx, by, bz);
      cull_item_type it;
      it = '{mode, slot, ax, ay, az, aw, bx, by, bz};
      return it;
   endfunction

   function automatic cull_item_type random_bits(input logic [1:0] mode);
      return make_item(mode, 3'($urandom), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
   endfunction

   // Uniform fixed-point value in [-span, span], span given in raw units.
   function automatic logic signed [WORD_W-1:0] fixed_in(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // A plane with a roughly unit normal and an offset that mostly keeps the
   // origin on the inside; now and then a plane of arbitrary bits.
   function automatic cull_item_type random_plane(input logic [2:0] slot);
      cull_item_type it;
      it = random_bits(MODE_LOAD);
      it.slot = slot;
      if ($urandom_range(0, 3) != 0) begin
         it.ax = fixed_in(ONE);
         it.ay = fixed_in(ONE);
         it.az = fixed_in(ONE);
         it.aw = int'($urandom_range(0, 80 * ONE)) - 8 * ONE;
      end
      return it;
   endfunction

   // A box around a point in the working volume; an axis is sometimes given
   // with its min and max swapped.
   function automatic cull_item_type random_box();
      cull_item_type            it;
      logic signed [WORD_W-1:0] centre [3];
      logic signed [WORD_W-1:0] half [3];
      logic signed [WORD_W-1:0] lo [3];
      logic signed [WORD_W-1:0] hi [3];
      it = random_bits(MODE_BOX);
      for (int k = 0; k < 3; k++) begin
         centre[k] = fixed_in(64 * ONE);
         half[k]   = $urandom_range(0, 16 * ONE);
         lo[k]     = centre[k] - half[k];
         hi[k]     = centre[k] + half[k];
         if ($urandom_range(0, 9) == 0) begin
            lo[k] = centre[k] + half[k];
            hi[k] = centre[k] - half[k];
         end
      end
      it.ax = lo[0];
      it.ay = lo[1];
      it.az = lo[2];
      it.bx = hi[0];
      it.by = hi[1];
      it.bz = hi[2];
      return it;
   endfunction

   // Radius is occasionally zero or negative, which the block uses as given.
   function automatic cull_item_type random_sphere();
      cull_item_type it;
      it = random_bits(MODE_SPHERE);
      it.ax = fixed_in(64 * ONE);
      it.ay = fixed_in(64 * ONE);
      it.az = fixed_in(64 * ONE);
      it.aw = int'($urandom_range(0, 26 * ONE)) - 2 * ONE;
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side.
   // ---------------------------------------------------------------------

   // Offer one item and return at the clock edge where it was transferred.
   // The payload is only changed here, so it holds steady while stalled.
   task automatic offer(input cull_item_type it);
      req_valid       <= 1'b1;
      req_mode        <= it.mode;
      req_plane_index <= it.slot;
      req_ax          <= it.ax;
      req_ay          <= it.ay;
      req_az          <= it.az;
      req_aw          <= it.aw;
      req_bx          <= it.bx;
      req_by          <= it.by;
      req_bz          <= it.bz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (it.mode == MODE_LOAD && it.slot < NUM_PLANES) loads_sent++;
      else if (it.mode == MODE_BOX) boxes_sent++;
      else if (it.mode == MODE_SPHERE) spheres_sent++;
      else ignored_sent++;
   endtask

   // Possibly leave a random gap with valid low, then offer the item. A gap
   // always waits on the clock, so valid is never lowered and raised
   // within the same time step.
   task automatic send(input cull_item_type it, input int gap_pct);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      offer(it);
      if (!(it.mode == MODE_UNUSED || (it.mode == MODE_LOAD && it.slot >= NUM_PLANES)))
         useful_issued++;
   endtask

   // Stop offering and wait until every predicted result has been seen.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (visible_outstanding != 0) @(posedge clock);
   endtask

   // Random traffic. Most of it is well formed: a fresh set of six planes now
   // and then, followed by a run of box and sphere tests. The rest is single
   // plane rewrites, transfers the block must drop, and tests with arbitrary
   // bit patterns.
   task automatic run_random(input int count, input int gap_pct);
      int            goal;
      int            pick;
      cull_item_type it;
      goal = useful_issued + count;
      while (useful_issued < goal) begin
         if ($urandom_range(0, 29) == 0) begin
            for (int s = 0; s < NUM_PLANES; s++) send(random_plane(3'(s)), gap_pct);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               it = random_bits(MODE_LOAD);
               if ($urandom_range(0, 1) == 0) it.mode = MODE_UNUSED;
               else it.slot = 3'($urandom_range(NUM_PLANES, 7));
            end else if (pick < 10) begin
               it = random_plane(3'($urandom_range(0, NUM_PLANES - 1)));
            end else if (pick < 15) begin
               it = random_bits(($urandom_range(0, 1) == 0) ? MODE_BOX : MODE_SPHERE);
            end else if (pick < 57) begin
               it = random_box();
            end else begin
               it = random_sphere();
            end
            send(it, gap_pct);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      cull_item_type directed [$];

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the store all zero after reset, every box is culled and a sphere
      // survives only with a positive radius.
      directed.push_back(make_item(MODE_BOX, 3'd0, -ONE, -ONE, -ONE, 0, ONE, ONE, ONE));
      directed.push_back(make_item(MODE_SPHERE, 3'd0, 0, 0, 0, ONE, 0, 0, 0));
      directed.push_back(make_item(MODE_SPHERE, 3'd0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_item(MODE_SPHERE, 3'd0, 0, 0, 0, -1, 0, 0, 0));
      directed.push_back(make_item(MODE_SPHERE, 3'd0, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h7fff_ffff, 0, 0, 0));
      directed.push_back(make_item(MODE_SPHERE, 3'd0, 32'h7fff_ffff, 0, 0, 32'h8000_0000,
                                   0, 0, 0));
      // Loads to slots past the last plane and the unused mode must not touch
      // the store; the sphere after them still sees all-zero planes.
      directed.push_back(make_item(MODE_LOAD, 3'd6, ONE, 0, 0, -100 * ONE, 0, 0, 0));
      directed.push_back(make_item(MODE_LOAD, 3'd7, -ONE, ONE, ONE, -100 * ONE, 0, 0, 0));
      directed.push_back(random_bits(MODE_UNUSED));
      directed.push_back(make_item(MODE_SPHERE, 3'd0, 0, 0, 0, 1, 0, 0, 0));
      // A cube frustum of half width 10.
      directed.push_back(make_item(MODE_LOAD, 3'd0,  ONE, 0, 0, 10 * ONE, 0, 0, 0));
      directed.push_back(make_item(MODE_LOAD, 3'd1, -ONE, 0, 0, 10 * ONE, 0, 0, 0));
      directed.push_back(make_item(MODE_LOAD, 3'd2, 0,  ONE, 0, 10 * ONE, 0, 0, 0));
      directed.push_back(make_item(MODE_LOAD, 3'd3, 0, -ONE, 0, 10 * ONE, 0, 0, 0));
      directed.push_back(make_item(MODE_LOAD, 3'd4, 0, 0,  ONE, 10 * ONE, 0, 0, 0));
      directed.push_back(make_item(MODE_LOAD, 3'd5, 0, 0, -ONE, 10 * ONE, 0, 0, 0));
      // Inside; just touching a face from outside (sum exactly zero, culled);
      // min and max corners given the wrong way round.
      directed.push_back(make_item(MODE_BOX, 3'd0, -ONE, -ONE, -ONE, 0, ONE, ONE, ONE));
      directed.push_back(make_item(MODE_BOX, 3'd0, 10 * ONE, 0, 0, 0, 20 * ONE, ONE, ONE));
      directed.push_back(make_item(MODE_BOX, 3'd0, 5 * ONE, 5 * ONE, 5 * ONE, 0,
                                   -5 * ONE, -5 * ONE, -5 * ONE));
      // Sphere tangent to a face from outside, then one raw unit larger.
      directed.push_back(make_item(MODE_SPHERE, 3'd0, 12 * ONE, 0, 0, 2 * ONE, 0, 0, 0));
      directed.push_back(make_item(MODE_SPHERE, 3'd0, 12 * ONE, 0, 0, 2 * ONE + 1,
                                   0, 0, 0));
      // Extreme coefficients and corners, so the widest sums are formed.
      directed.push_back(make_item(MODE_LOAD, 3'd0, 32'h8000_0000, 32'h7fff_ffff, -1,
                                   32'h8000_0000, 0, 0, 0));
      directed.push_back(make_item(MODE_BOX, 3'd0, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                                   32'h7fff_ffff));
      directed.push_back(make_item(MODE_SPHERE, 3'd0, 32'h7fff_ffff, 32'h8000_0000,
                                   32'h8000_0000, 32'h7fff_ffff, 0, 0, 0));
      directed.push_back(make_item(MODE_LOAD, 3'd0, ONE, 0, 0, 10 * ONE, 0, 0, 0));

      foreach (directed[i]) send(directed[i], 0);
      wait_for_results();

      // Moderate idling on both sides.
      rx_stall_pct = 15;
      run_random(600, 20);

      // Back pressure: the receiver holds off for a long stretch while the
      // sender keeps offering back to back, so the queue fills and req_stall
      // rises. Then the sender pauses until every result is in.
      hold_asks++;
      run_random(40, 0);
      wait_for_results();

      // A stretch with no idling at all.
      rx_stall_pct = 0;
      run_random(200, 0);

      // Heavy idling on both sides.
      rx_stall_pct = 35;
      run_random(600, 40);
      wait_for_results();

      // Final part of the run runs flat out.
      rx_stall_pct = 0;
      run_random(TARGET_ITEMS - useful_issued, 0);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d plane loads, %0d box tests, %0d sphere tests",
               loads_sent, boxes_sent, spheres_sent);
      $display("and %0d dropped transfers; %0d results compared, %0d of them visible.",
               ignored_sent, results_checked, visible_seen);
      if (mismatch_count == 0 && visible_outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatch_count, visible_outstanding);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
